>>> rtl/core/wrsg_pkg.sv
// Shared types, widths and constants of the weighted residual safety gate.
package wrsg_pkg;

    localparam int MAX_PLANES     = 8;
    localparam int NUM_PLANES_DEF = 8;
    localparam int PLANE_W        = 3;

    localparam int COORD_W  = 18;
    localparam int MAG_W    = 17;
    localparam int WEIGHT_W = 16;
    localparam int SQ_W     = 33;
    localparam int PROD_W   = SQ_W + WEIGHT_W;
    localparam int GRP_W    = PROD_W + 2;
    localparam int SUM_W    = PROD_W + 3;
    localparam int RES_W    = 24;
    localparam int FRAC_SHIFT = 28;
    localparam int EPS_W    = 16;
    localparam int LIMIT_W  = 17;
    localparam int LANES_PER_GROUP = 4;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_LO = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_HI = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_HARD_LIMIT = CFG_IDX_W'(3);

    localparam logic [CFG_DATA_W-1:0] WEIGHTS_RESET = 64'h1000_1000_1000_1000;
    localparam logic [EPS_W-1:0]      EPSILON_RESET = 16'd66;
    localparam logic [LIMIT_W-1:0]    ONE_Q16       = 17'd65536;

    typedef enum logic [1:0] {
        VERDICT_OK      = 2'd0,
        VERDICT_INVALID = 2'd1,
        VERDICT_BREACH  = 2'd2,
        VERDICT_RISE    = 2'd3
    } verdict_t;

    typedef struct packed {
        logic s1_en;
        logic s2_en;
    } lane_ctl_t;

    typedef struct packed {
        logic s3_en;
        logic out_en;
    } merge_ctl_t;

    typedef struct packed {
        logic ok;
        logic breach;
    } lane_flags_t;

endpackage

>>> rtl/core/wrsg_lane.sv
// One plane lane: range and limit checks, coordinate square, weighted product.
module wrsg_lane
    import wrsg_pkg::*;
(
    input  logic                      clk,
    input  lane_ctl_t                 ctl,
    input  logic signed [COORD_W-1:0] coord,
    input  logic [WEIGHT_W-1:0]       weight,
    input  logic [LIMIT_W-1:0]        coord_ceiling,
    output lane_flags_t               flags,
    output logic [PROD_W-1:0]         prod
);

    logic [MAG_W-1:0]   mag;
    logic [2*MAG_W-1:0] sq_full;
    lane_flags_t        flags1_next;
    lane_flags_t        flags1_reg;
    logic [SQ_W-1:0]    sq_reg;
    lane_flags_t        flags2_reg;
    logic [PROD_W-1:0]  prod_next;
    logic [PROD_W-1:0]  prod_reg;

    assign mag     = coord[MAG_W-1:0];
    assign sq_full = mag * mag;

    // A coordinate is in range when it is not negative and at most 1.0.
    assign flags1_next.ok     = !coord[COORD_W-1] && (mag <= ONE_Q16);
    assign flags1_next.breach = (mag >= coord_ceiling);

    assign prod_next = weight * sq_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.s1_en)
        begin
            sq_reg     <= sq_full[SQ_W-1:0];
            flags1_reg <= flags1_next;
        end
        if (ctl.s2_en)
        begin
            prod_reg   <= prod_next;
            flags2_reg <= flags1_reg;
        end
    end

    assign flags = flags2_reg;
    assign prod  = prod_reg;

endmodule

>>> rtl/core/wrsg_merge.sv
// Merge stage: sums the lane products, applies the checks in order, holds the residual.
module wrsg_merge
    import wrsg_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  merge_ctl_t           ctl,
    input  logic [PROD_W-1:0]    prod [NUM_PLANES],
    input  lane_flags_t          flags [NUM_PLANES],
    input  logic                 marked,
    input  logic [EPS_W-1:0]     epsilon,
    output logic                 accepted,
    output logic [1:0]           verdict,
    output logic [PLANE_W-1:0]   violating_plane,
    output logic [RES_W-1:0]     proposed_residual,
    output logic [RES_W-1:0]     stored_residual
);

    localparam int NUM_GROUPS = (NUM_PLANES + LANES_PER_GROUP - 1) / LANES_PER_GROUP;
    localparam int PAD_LANES  = NUM_GROUPS * LANES_PER_GROUP;

    logic [PROD_W-1:0]     prod_pad [PAD_LANES];
    logic [GRP_W-1:0]      grp_sum_next [NUM_GROUPS];
    logic [GRP_W-1:0]      grp_sum_reg  [NUM_GROUPS];
    logic                  ok_next;
    logic                  ok_reg;
    logic [NUM_PLANES-1:0] breach_next;
    logic [NUM_PLANES-1:0] breach_reg;

    logic [SUM_W-1:0]      total;
    logic [RES_W-1:0]      proposed_calc;
    logic [RES_W:0]        bound;
    logic [PLANE_W-1:0]    first_plane;
    verdict_t              verdict_calc;
    logic [PLANE_W-1:0]    plane_calc;
    logic [RES_W-1:0]      proposed_out;

    logic [RES_W-1:0]      held_reg;
    logic [RES_W-1:0]      held_next;

    logic                  accepted_reg;
    verdict_t              verdict_reg;
    logic [PLANE_W-1:0]    plane_reg;
    logic [RES_W-1:0]      proposed_reg;
    logic [RES_W-1:0]      stored_reg;

    for (genvar k = 0; k < PAD_LANES; k++)
    begin : g_pad
        if (k < NUM_PLANES)
        begin : g_live
            assign prod_pad[k] = prod[k];
        end
        else
        begin : g_zero
            assign prod_pad[k] = '0;
        end
    end

    // First merge stage: partial sums over groups of four lanes, flags gathered.
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_sum_next[g] = '0;
            for (int j = 0; j < LANES_PER_GROUP; j++)
            begin
                grp_sum_next[g] = grp_sum_next[g]
                                  + GRP_W'(prod_pad[g*LANES_PER_GROUP + j]);
            end
        end
        ok_next = marked;
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            ok_next        = ok_next && flags[i].ok;
            breach_next[i] = flags[i].breach;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s3_en)
        begin
            grp_sum_reg <= grp_sum_next;
            ok_reg      <= ok_next;
            breach_reg  <= breach_next;
        end
    end

    // Second merge stage: final add, truncation to Q8.16, checks in order.
    always_comb
    begin
        total = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            total = total + SUM_W'(grp_sum_reg[g]);
        end
        proposed_calc = total[FRAC_SHIFT +: RES_W];
        bound = {1'b0, held_reg} + (RES_W+1)'(epsilon);

        first_plane = '0;
        for (int i = NUM_PLANES - 1; i >= 0; i--)
        begin
            if (breach_reg[i])
            begin
                first_plane = PLANE_W'(i);
            end
        end

        verdict_calc = VERDICT_OK;
        plane_calc   = '0;
        proposed_out = '0;
        held_next    = held_reg;
        if (!ok_reg)
        begin
            verdict_calc = VERDICT_INVALID;
        end
        else if (|breach_reg)
        begin
            verdict_calc = VERDICT_BREACH;
            plane_calc   = first_plane;
        end
        else
        begin
            proposed_out = proposed_calc;
            if ({1'b0, proposed_calc} > bound)
            begin
                verdict_calc = VERDICT_RISE;
            end
            else
            begin
                held_next = proposed_calc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (ctl.out_en)
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_en)
        begin
            accepted_reg <= (verdict_calc == VERDICT_OK);
            verdict_reg  <= verdict_calc;
            plane_reg    <= plane_calc;
            proposed_reg <= proposed_out;
            stored_reg   <= held_next;
        end
    end

    assign accepted          = accepted_reg;
    assign verdict           = verdict_reg;
    assign violating_plane   = plane_reg;
    assign proposed_residual = proposed_reg;
    assign stored_residual   = stored_reg;

endmodule

>>> rtl/core/weighted_residual_safety_gate_unit.sv
// Top level of the weighted residual safety gate: lanes, merge, pipeline control, registers.
//
// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  ---------------------------------------------
// in        sink       in_valid / in_ready    coord_energy .. coord_sensor, vector_marked_valid
// out       source     out_valid / out_ready  accepted, verdict, violating_plane,
//                                             proposed_residual, stored_residual
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each item is registered in lane stages one and two, then in the first merge stage and
// then in the output register; the block sustains one item per cycle while out_ready
// stays high. The rate is set by the loop in the last merge stage, where the residual
// is compared with the held value and the held value is updated. Reset clears all
// stage valid bits, returns the registers to their defaults and zeroes the held
// residual. When out_ready is low the stages fill behind the output register, and
// in_ready drops only once all four stages hold an item.
module weighted_residual_safety_gate_unit
    import wrsg_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] coord_energy,
    input  logic signed [COORD_W-1:0] coord_hydraulic,
    input  logic signed [COORD_W-1:0] coord_biology,
    input  logic signed [COORD_W-1:0] coord_carbon,
    input  logic signed [COORD_W-1:0] coord_materials,
    input  logic signed [COORD_W-1:0] coord_thermal,
    input  logic signed [COORD_W-1:0] coord_mechanical,
    input  logic signed [COORD_W-1:0] coord_sensor,
    input  logic                      vector_marked_valid,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      accepted,
    output logic [1:0]                verdict,
    output logic [PLANE_W-1:0]        violating_plane,
    output logic [RES_W-1:0]          proposed_residual,
    output logic [RES_W-1:0]          stored_residual,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers. Writes are always taken; an index past the
    // last register is dropped.
    logic [CFG_DATA_W-1:0] weights_lo_reg;
    logic [CFG_DATA_W-1:0] weights_hi_reg;
    logic [EPS_W-1:0]      epsilon_reg;
    logic [LIMIT_W-1:0]    coord_ceiling_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_lo_reg    <= WEIGHTS_RESET;
            weights_hi_reg    <= WEIGHTS_RESET;
            epsilon_reg       <= EPSILON_RESET;
            coord_ceiling_reg <= ONE_Q16;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WEIGHTS_LO: weights_lo_reg    <= cfg_data;
                REG_WEIGHTS_HI: weights_hi_reg    <= cfg_data;
                REG_EPSILON:    epsilon_reg       <= cfg_data[EPS_W-1:0];
                REG_HARD_LIMIT: coord_ceiling_reg <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control. Each stage moves forward when the stage after it is
    // empty or is itself moving, so bubbles are squeezed out under a stall.
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic v1_next, v2_next, v3_next, vo_next;
    logic s1_free, s2_free, s3_free, out_free;
    lane_ctl_t  lane_ctl;
    merge_ctl_t merge_ctl;

    assign out_free = !vo_reg || out_ready;
    assign s3_free  = !v3_reg || out_free;
    assign s2_free  = !v2_reg || s3_free;
    assign s1_free  = !v1_reg || s2_free;
    assign in_ready = s1_free;

    assign lane_ctl.s1_en   = in_valid && s1_free;
    assign lane_ctl.s2_en   = v1_reg && s2_free;
    assign merge_ctl.s3_en  = v2_reg && s3_free;
    assign merge_ctl.out_en = v3_reg && out_free;

    assign v1_next = s1_free  ? in_valid : v1_reg;
    assign v2_next = s2_free  ? v1_reg   : v2_reg;
    assign v3_next = s3_free  ? v2_reg   : v3_reg;
    assign vo_next = out_free ? v3_reg   : vo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            vo_reg <= vo_next;
        end
    end

    assign out_valid = vo_reg;

    // The producer's valid flag rides along with the lane stages.
    logic marked_s1_reg;
    logic marked_s2_reg;

    always_ff @(posedge clk)
    begin
        if (lane_ctl.s1_en)
        begin
            marked_s1_reg <= vector_marked_valid;
        end
        if (lane_ctl.s2_en)
        begin
            marked_s2_reg <= marked_s1_reg;
        end
    end

    // Coordinates and weights laid out by plane. Planes at or above
    // NUM_PLANES get no lane and their coordinates play no part.
    logic signed [COORD_W-1:0] coord [MAX_PLANES];
    logic [WEIGHT_W-1:0]       weight [NUM_PLANES];
    logic [PROD_W-1:0]         prod [NUM_PLANES];
    lane_flags_t               flags [NUM_PLANES];

    assign coord[0] = coord_energy;
    assign coord[1] = coord_hydraulic;
    assign coord[2] = coord_biology;
    assign coord[3] = coord_carbon;
    assign coord[4] = coord_materials;
    assign coord[5] = coord_thermal;
    assign coord[6] = coord_mechanical;
    assign coord[7] = coord_sensor;

    for (genvar i = 0; i < NUM_PLANES; i++)
    begin : g_lane
        if (i < LANES_PER_GROUP)
        begin : g_lo
            assign weight[i] = weights_lo_reg[WEIGHT_W*i +: WEIGHT_W];
        end
        else
        begin : g_hi
            assign weight[i] = weights_hi_reg[WEIGHT_W*(i-LANES_PER_GROUP) +: WEIGHT_W];
        end

        wrsg_lane u_lane (
            .clk           (clk),
            .ctl           (lane_ctl),
            .coord         (coord[i]),
            .weight        (weight[i]),
            .coord_ceiling (coord_ceiling_reg),
            .flags         (flags[i]),
            .prod          (prod[i])
        );
    end

    wrsg_merge #(
        .NUM_PLANES (NUM_PLANES)
    ) u_merge (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (merge_ctl),
        .prod              (prod),
        .flags             (flags),
        .marked            (marked_s2_reg),
        .epsilon           (epsilon_reg),
        .accepted          (accepted),
        .verdict           (verdict),
        .violating_plane   (violating_plane),
        .proposed_residual (proposed_residual),
        .stored_residual   (stored_residual)
    );

    // The input side stalls only when every stage holds an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && vo_reg))
        else $error("input stalled while a pipeline stage is empty");

    // The accept bit and the verdict code agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (accepted == (verdict == VERDICT_OK)))
        else $error("accepted does not match verdict");

    // An accepted step stores exactly the residual it proposed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> (stored_residual == proposed_residual))
        else $error("stored residual differs from the accepted proposal");

    // A plane is reported only for a breach, and a residual only once the
    // validity and limit checks pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (verdict == VERDICT_INVALID || verdict == VERDICT_BREACH))
        |-> (proposed_residual == '0))
        else $error("residual reported for an item rejected before the sum");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && verdict != VERDICT_BREACH) |-> (violating_plane == '0))
        else $error("plane reported without a breach");

endmodule

>>> tb/wrsg_gate_checker.sv
// Checker for the weighted residual safety gate: predicts every output item and compares it.
module wrsg_gate_checker
    import wrsg_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [MAX_PLANES-1:0][COORD_W-1:0]  coords,
    input  logic                                vector_marked_valid,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                accepted,
    input  logic [1:0]                          verdict,
    input  logic [PLANE_W-1:0]                  violating_plane,
    input  logic [RES_W-1:0]                    proposed_residual,
    input  logic [RES_W-1:0]                    stored_residual,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [CFG_DATA_W-1:0]               cfg_data,
    output int                                  mismatch_count,
    output int                                  outstanding_items
);

    typedef struct packed {
        logic               accepted;
        verdict_t           verdict;
        logic [PLANE_W-1:0] plane;
        logic [RES_W-1:0]   proposed;
        logic [RES_W-1:0]   stored;
    } gate_result_t;

    logic [CFG_DATA_W-1:0] weights_lo;
    logic [CFG_DATA_W-1:0] weights_hi;
    logic [EPS_W-1:0]      epsilon;
    logic [LIMIT_W-1:0]    coord_ceiling;
    logic [RES_W-1:0]      held_residual;
    gate_result_t          pending_verdicts[$];
    gate_result_t          oldest;

    // Works out the verdict of one vector and updates the held residual on acceptance.
    function automatic gate_result_t predict_gate_step(
        input logic [MAX_PLANES-1:0][COORD_W-1:0] crd,
        input logic                               flag
    );
        gate_result_t        res;
        int                  value [MAX_PLANES];
        logic                vec_ok;
        logic [63:0]         weighted_sum;
        logic [63:0]         mag;
        logic [WEIGHT_W-1:0] w;
        res = '0;
        vec_ok = flag;
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            value[i] = int'($signed(crd[i]));
            if (value[i] < 0 || value[i] > 65536)
                vec_ok = 1'b0;
        end
        if (!vec_ok)
        begin
            res.verdict = VERDICT_INVALID;
        end
        else
        begin
            // Scanning downward leaves the lowest breaching plane in the result.
            for (int i = NUM_PLANES - 1; i >= 0; i--)
            begin
                if (value[i] >= int'(coord_ceiling))
                begin
                    res.verdict = VERDICT_BREACH;
                    res.plane = PLANE_W'(i);
                end
            end
            if (res.verdict == VERDICT_OK)
            begin
                weighted_sum = '0;
                for (int i = 0; i < NUM_PLANES; i++)
                begin
                    if (i < LANES_PER_GROUP)
                        w = WEIGHT_W'(weights_lo >> (WEIGHT_W * (i % LANES_PER_GROUP)));
                    else
                        w = WEIGHT_W'(weights_hi >> (WEIGHT_W * (i % LANES_PER_GROUP)));
                    mag = 64'(value[i]);
                    weighted_sum = weighted_sum + 64'(w) * (mag * mag);
                end
                res.proposed = RES_W'(weighted_sum >> FRAC_SHIFT);
                if (64'(res.proposed) > 64'(held_residual) + 64'(epsilon))
                    res.verdict = VERDICT_RISE;
                else
                    held_residual = res.proposed;
            end
        end
        res.accepted = (res.verdict == VERDICT_OK);
        res.stored = held_residual;
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s differs, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_lo = WEIGHTS_RESET;
            weights_hi = WEIGHTS_RESET;
            epsilon = EPSILON_RESET;
            coord_ceiling = ONE_Q16;
            held_residual = '0;
            pending_verdicts.delete();
            mismatch_count = 0;
            outstanding_items = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WEIGHTS_LO: weights_lo = cfg_data;
                    REG_WEIGHTS_HI: weights_hi = cfg_data;
                    REG_EPSILON:    epsilon = cfg_data[EPS_W-1:0];
                    REG_HARD_LIMIT: coord_ceiling = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                pending_verdicts.push_back(predict_gate_step(coords, vector_marked_valid));
            if (out_valid && out_ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: output item with nothing expected, actual %0h %0h %0h %0h %0h",
                             $time, accepted, verdict, violating_plane, proposed_residual,
                             stored_residual);
                    mismatch_count++;
                end
                else
                begin
                    oldest = pending_verdicts.pop_front();
                    compare_field("accepted", 32'(oldest.accepted), 32'(accepted));
                    compare_field("verdict", 32'(oldest.verdict), 32'(verdict));
                    compare_field("violating_plane", 32'(oldest.plane), 32'(violating_plane));
                    compare_field("proposed_residual", 32'(oldest.proposed),
                                  32'(proposed_residual));
                    compare_field("stored_residual", 32'(oldest.stored), 32'(stored_residual));
                end
            end
            outstanding_items = pending_verdicts.size();
        end
    end

endmodule

>>> tb/tb_weighted_residual_safety_gate_unit.sv
// Testbench top for the weighted residual safety gate: stimulus, configuration phases and verdict.
module tb_weighted_residual_safety_gate_unit
    import wrsg_pkg::*;
();

    // Indexes outside the register map; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LAST  = CFG_IDX_W'(255);

    localparam int ITEMS_PER_PHASE = 85;
    localparam int PHASE_COUNT     = 8;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [COORD_W-1:0] coord_energy;
    logic signed [COORD_W-1:0] coord_hydraulic;
    logic signed [COORD_W-1:0] coord_biology;
    logic signed [COORD_W-1:0] coord_carbon;
    logic signed [COORD_W-1:0] coord_materials;
    logic signed [COORD_W-1:0] coord_thermal;
    logic signed [COORD_W-1:0] coord_mechanical;
    logic signed [COORD_W-1:0] coord_sensor;
    logic                      vector_marked_valid;
    logic                      out_valid;
    logic                      out_ready;
    logic                      accepted;
    logic [1:0]                verdict;
    logic [PLANE_W-1:0]        violating_plane;
    logic [RES_W-1:0]          proposed_residual;
    logic [RES_W-1:0]          stored_residual;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    int mismatch_count;
    int outstanding_items;

    // Percentages of cycles in which the sender holds back or the receiver stalls.
    int sender_idle_pct;
    int receiver_stall_pct;

    // The limit last written, so that well-formed vectors can be kept below it, and the
    // position of the random walk that produces slowly drifting vectors.
    logic [LIMIT_W-1:0]                 gate_limit;
    logic [MAX_PLANES-1:0][COORD_W-1:0] walk_pos;

    weighted_residual_safety_gate_unit #(
        .NUM_PLANES (NUM_PLANES_DEF)
    ) u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .coord_energy        (coord_energy),
        .coord_hydraulic     (coord_hydraulic),
        .coord_biology       (coord_biology),
        .coord_carbon        (coord_carbon),
        .coord_materials     (coord_materials),
        .coord_thermal       (coord_thermal),
        .coord_mechanical    (coord_mechanical),
        .coord_sensor        (coord_sensor),
        .vector_marked_valid (vector_marked_valid),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .accepted            (accepted),
        .verdict             (verdict),
        .violating_plane     (violating_plane),
        .proposed_residual   (proposed_residual),
        .stored_residual     (stored_residual),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    // The checker sees the same channels as the block and reports how many mismatches it found
    // and how many predicted results are still waiting.
    wrsg_gate_checker #(
        .NUM_PLANES (NUM_PLANES_DEF)
    ) u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .coords              ({coord_sensor, coord_mechanical, coord_thermal, coord_materials,
                               coord_carbon, coord_biology, coord_hydraulic, coord_energy}),
        .vector_marked_valid (vector_marked_valid),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .accepted            (accepted),
        .verdict             (verdict),
        .violating_plane     (violating_plane),
        .proposed_residual   (proposed_residual),
        .stored_residual     (stored_residual),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .mismatch_count      (mismatch_count),
        .outstanding_items   (outstanding_items)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // The receiver decides afresh at every falling edge whether it takes an item.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Every plane set to the same coordinate.
    function automatic logic [MAX_PLANES-1:0][COORD_W-1:0] uniform_vector(
        input logic [COORD_W-1:0] value
    );
        logic [MAX_PLANES-1:0][COORD_W-1:0] vec;
        for (int i = 0; i < MAX_PLANES; i++)
            vec[i] = value;
        return vec;
    endfunction

    // Presents one item after a random number of idle cycles and holds it until the
    // block takes it. Valid stays high across back-to-back items, so within one falling
    // edge it is assigned only once.
    task automatic send_vector(input logic [MAX_PLANES-1:0][COORD_W-1:0] crd,
                               input logic flag);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid            <= 1'b1;
        coord_energy        <= crd[0];
        coord_hydraulic     <= crd[1];
        coord_biology       <= crd[2];
        coord_carbon        <= crd[3];
        coord_materials     <= crd[4];
        coord_thermal       <= crd[5];
        coord_mechanical    <= crd[6];
        coord_sensor        <= crd[7];
        vector_marked_valid <= flag;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Writes all four registers. The narrow registers get random upper bits, which the
    // block must drop.
    task automatic program_gate(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                                input logic [EPS_W-1:0] eps, input logic [LIMIT_W-1:0] limit);
        logic [CFG_DATA_W-1:0] junk;
        junk = {$urandom, $urandom};
        write_reg(REG_WEIGHTS_LO, lo);
        write_reg(REG_WEIGHTS_HI, hi);
        write_reg(REG_EPSILON, {junk[CFG_DATA_W-1:EPS_W], eps});
        write_reg(REG_HARD_LIMIT, {junk[CFG_DATA_W-1:LIMIT_W], limit});
        gate_limit = limit;
    endtask

    // Lowers valid, then waits until every predicted item has come out of the four-stage
    // pipeline, so that the block is idle for a register write.
    // The count is read at the falling edge, away from the checker's update.
    task automatic drain_gate();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding_items != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Most items are a random walk inside the valid corridor, so the residual moves by
    // amounts comparable to the margin and both acceptance and the rise check are hit
    // often. The rest are halving steps, fresh valid vectors, deliberate breaches and
    // noise that is mostly invalid.
    task automatic next_random_vector(output logic [MAX_PLANES-1:0][COORD_W-1:0] crd,
                                      output logic flag);
        int kind;
        int step;
        int span;
        int pos;
        int hit;
        kind = $urandom_range(99);
        step = 1 << $urandom_range(12, 3);
        hit  = $urandom_range(MAX_PLANES - 1);
        if (gate_limit == '0)
            span = 0;
        else if (gate_limit > ONE_Q16)
            span = 65536;
        else
            span = int'(gate_limit) - 1;
        for (int i = 0; i < MAX_PLANES; i++)
        begin
            pos = int'(walk_pos[i]);
            if (kind < 55)
                pos = pos + int'($urandom_range(2 * step)) - step;
            else if (kind < 65)
                pos = pos / 2;
            else if (kind < 75)
                pos = int'($urandom_range(span));
            if (pos < 0)
                pos = 0;
            if (pos > span)
                pos = span;
            walk_pos[i] = COORD_W'(pos);
        end
        crd  = walk_pos;
        flag = ($urandom_range(39) != 0);
        if (kind >= 75 && kind < 87)
        begin
            // A breach needs a valid coordinate at or above the limit.
            if (gate_limit <= ONE_Q16)
                crd[hit] = COORD_W'($urandom_range(int'(gate_limit), 65536));
        end
        else if (kind >= 87)
        begin
            if ($urandom_range(1) == 1)
            begin
                crd[hit] = ($urandom_range(1) == 1) ? 18'h3FFFF : 18'd65537;
            end
            else
            begin
                for (int i = 0; i < MAX_PLANES; i++)
                    crd[i] = COORD_W'($urandom);
                flag = 1'($urandom_range(1));
            end
        end
    endtask

    initial
    begin
        logic [MAX_PLANES-1:0][COORD_W-1:0] vec;
        logic                               flag;

        rst_n               = 1'b0;
        in_valid            = 1'b0;
        coord_energy        = '0;
        coord_hydraulic     = '0;
        coord_biology       = '0;
        coord_carbon        = '0;
        coord_materials     = '0;
        coord_thermal       = '0;
        coord_mechanical    = '0;
        coord_sensor        = '0;
        vector_marked_valid = 1'b0;
        out_ready           = 1'b0;
        cfg_valid           = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        sender_idle_pct     = 0;
        receiver_stall_pct  = 0;
        gate_limit          = ONE_Q16;
        walk_pos            = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed items with the reset configuration: zero residual, a clear flag,
        // negative and oversized coordinates, a breach at exactly 1.0, the lowest
        // breaching plane winning, and small steps around the default margin.
        send_vector(uniform_vector('0), 1'b1);
        send_vector(uniform_vector('0), 1'b0);
        vec = uniform_vector('0);
        vec[0] = 18'h20000;
        send_vector(vec, 1'b1);
        vec = uniform_vector('0);
        vec[7] = 18'h1FFFF;
        send_vector(vec, 1'b1);
        vec = uniform_vector('0);
        vec[3] = 18'd65537;
        send_vector(vec, 1'b1);
        vec = uniform_vector('0);
        vec[1] = 18'h3FFFF;
        send_vector(vec, 1'b1);
        send_vector(uniform_vector(18'd65535), 1'b1);
        vec = uniform_vector('0);
        vec[3] = 18'd65536;
        send_vector(vec, 1'b1);
        vec = uniform_vector('0);
        vec[5] = 18'd65536;
        vec[7] = 18'd65536;
        send_vector(vec, 1'b1);
        vec = uniform_vector('0);
        vec[0] = 18'd4096;
        send_vector(vec, 1'b1);
        vec[0] = 18'd2048;
        send_vector(vec, 1'b1);
        vec[1] = 18'd2048;
        send_vector(vec, 1'b1);
        send_vector(uniform_vector(18'd2048), 1'b1);
        send_vector(uniform_vector('0), 1'b1);
        drain_gate();

        // Zero limit: any valid vector breaches at plane 0, but invalid ones still
        // report as invalid first.
        program_gate(WEIGHTS_RESET, WEIGHTS_RESET, EPSILON_RESET, '0);
        send_vector(uniform_vector('0), 1'b1);
        send_vector(uniform_vector('0), 1'b0);
        vec = uniform_vector('0);
        vec[2] = 18'd65537;
        send_vector(vec, 1'b1);
        drain_gate();

        // Largest weights, margin and limit: coordinates of exactly 1.0 pass the limit,
        // and the third item lands exactly on held residual plus margin.
        program_gate('1, '1, '1, '1);
        send_vector(uniform_vector(18'd65536), 1'b1);
        vec = uniform_vector('0);
        vec[0] = 18'd16384;
        send_vector(vec, 1'b1);
        send_vector(uniform_vector(18'd8192), 1'b1);
        drain_gate();

        // Writes outside the register map must leave the configuration alone.
        write_reg(REG_UNMAPPED_FIRST, {$urandom, $urandom});
        write_reg(REG_UNMAPPED_LAST, '1);
        send_vector(uniform_vector(18'd65536), 1'b1);
        send_vector(uniform_vector('0), 1'b1);
        drain_gate();

        // Random phases, each with its own configuration and flow-control pattern.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
                default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
            endcase
            case (phase)
                0: program_gate(WEIGHTS_RESET, WEIGHTS_RESET, EPSILON_RESET, ONE_Q16);
                1: program_gate({$urandom, $urandom}, {$urandom, $urandom},
                                EPS_W'($urandom_range(4000)),
                                LIMIT_W'($urandom_range(65536, 32768)));
                2: program_gate('1, '1, '1, '1);
                3: program_gate({$urandom, $urandom} & 64'h1FFF_1FFF_1FFF_1FFF,
                                {$urandom, $urandom} & 64'h1FFF_1FFF_1FFF_1FFF,
                                '0, ONE_Q16);
                4: program_gate('0, '0, '0, LIMIT_W'(1));
                5: program_gate({$urandom, $urandom}, {$urandom, $urandom},
                                EPS_W'($urandom), LIMIT_W'($urandom));
                6: program_gate(64'hFFFF_0000_FFFF_0001, {$urandom, $urandom},
                                EPS_W'(1000), LIMIT_W'(32768));
                default: program_gate({$urandom, $urandom}, {$urandom, $urandom},
                                      EPS_W'($urandom_range(300)),
                                      LIMIT_W'($urandom_range(65536, 40000)));
            endcase
            walk_pos = '0;
            repeat (ITEMS_PER_PHASE)
            begin
                next_random_vector(vec, flag);
                send_vector(vec, flag);
            end
            drain_gate();
        end

        if (mismatch_count == 0 && outstanding_items == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Guard against a hung handshake; far beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/wrsg_pkg.sv
rtl/core/wrsg_lane.sv
rtl/core/wrsg_merge.sv
rtl/core/weighted_residual_safety_gate_unit.sv
tb/wrsg_gate_checker.sv
tb/tb_weighted_residual_safety_gate_unit.sv
